@@ hw/rtl/ertm_pkg.sv @@
package ertm_pkg;

   // field widths of the pose and matrix entries
   localparam int ANGLE_BITS = 16;
   localparam int COEF_BITS  = 16;

   // number of series cells per angle
   localparam int NUM_CELLS = 5;

   // fractional part of half pi in Q0.32 (half pi = 1 + this / 2^32, scaled)
   localparam logic [31:0] HALF_PI_FRAC = 32'd2451551556;

   // one in Q2.30
   localparam logic [30:0] Q30_ONE = 31'h4000_0000;

   // request and response payloads
   typedef struct packed {
      logic signed [ANGLE_BITS-1:0] heading;
      logic signed [ANGLE_BITS-1:0] pitch;
      logic signed [ANGLE_BITS-1:0] bank;
      logic                         mode;
   } req_type;

   typedef struct packed {
      logic signed [COEF_BITS-1:0] m11;
      logic signed [COEF_BITS-1:0] m12;
      logic signed [COEF_BITS-1:0] m13;
      logic signed [COEF_BITS-1:0] m21;
      logic signed [COEF_BITS-1:0] m22;
      logic signed [COEF_BITS-1:0] m23;
      logic signed [COEF_BITS-1:0] m31;
      logic signed [COEF_BITS-1:0] m32;
      logic signed [COEF_BITS-1:0] m33;
   } rsp_type;

   // data handed from cell to cell for one angle
   typedef struct packed {
      logic [1:0]  quad;
      logic        fold;
      logic        mode;
      logic [29:0] x;
      logic [29:0] x2;
      logic [30:0] ps;
      logic [30:0] pc;
   } lane_type;

   // output rounding constants
   localparam int FRAC = COEF_BITS - 1;
   localparam int RSH  = (FRAC <= 30) ? 30 - FRAC : 0;
   localparam int LSH  = (FRAC > 30) ? FRAC - 30 : 0;
   localparam logic [33:0] RND  = (RSH > 0) ? (34'd1 << ((RSH > 0) ? RSH - 1 : 0)) : 34'd0;
   localparam logic [33:0] MAXP = (34'd1 << (COEF_BITS - 1)) - 34'd1;
   localparam logic [33:0] MAXN = 34'd1 << (COEF_BITS - 1);

   // q2.30 product, rounded half away from zero
   function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic        neg;
      logic [30:0] ma;
      logic [30:0] mb;
      logic [61:0] p;
      logic [30:0] m;
      neg = a[31] ^ b[31];
      ma  = a[31] ? 31'(-a) : 31'(a);
      mb  = b[31] ? 31'(-b) : 31'(b);
      p   = 62'(ma) * 62'(mb) + (62'd1 << 29);
      m   = 31'(p >> 30);
      return neg ? -32'(m) : 32'(m);
   endfunction

   // q2.30 sum to output format with rounding and saturation
   function automatic logic [COEF_BITS-1:0] to_coef(input logic signed [32:0] v);
      logic        neg;
      logic [32:0] mag;
      logic [33:0] m;
      logic [33:0] r;
      neg = v[32];
      mag = neg ? 33'(-v) : 33'(v);
      m   = (({1'b0, mag} + RND) >> RSH) << LSH;
      if (neg) begin
         r = (m > MAXN) ? ~MAXN + 34'd1 : ~m + 34'd1;
      end else begin
         r = (m > MAXP) ? MAXP : m;
      end
      return COEF_BITS'(r);
   endfunction

endpackage

@@ hw/rtl/ertm_prep.sv @@
module ertm_prep (
   input  logic                                 clock,
   input  logic                                 advance,
   input  logic signed [ertm_pkg::ANGLE_BITS-1:0] angle,
   input  logic                                 mode,
   output ertm_pkg::lane_type                   lane
);
   import ertm_pkg::*;

   logic [31:0] turn;
   logic [29:0] r;
   logic        fold;
   logic [29:0] t;
   logic [61:0] xprod;
   logic [59:0] sq;

   lane_type s1_in, s1_ff;
   lane_type s2_in, s2_ff;

   // quadrant split, octant fold, scale to radians
   always_comb begin
      turn  = 32'(angle) << (32 - ANGLE_BITS);
      r     = turn[29:0];
      fold  = r > 30'h2000_0000;
      t     = fold ? 30'(31'h4000_0000 - {1'b0, r}) : r;
      xprod = 62'(t) * 62'(HALF_PI_FRAC);
      s1_in      = '0;
      s1_in.quad = turn[31:30];
      s1_in.fold = fold;
      s1_in.mode = mode;
      s1_in.x    = t + 30'(xprod >> 32);
   end

   // square of the angle, series start at one
   always_comb begin
      sq       = 60'(s1_ff.x) * 60'(s1_ff.x);
      s2_in    = s1_ff;
      s2_in.x2 = 30'(sq >> 30);
      s2_in.ps = Q30_ONE;
      s2_in.pc = Q30_ONE;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
      end
   end

   assign lane = s2_ff;

endmodule

@@ hw/rtl/ertm_cell.sv @@
module ertm_cell #(
   parameter int DIV_S    = 72,
   parameter int DIV_C    = 90,
   parameter bit SIN_LAST = 1'b0
) (
   input  logic               clock,
   input  logic               advance,
   input  ertm_pkg::lane_type lane_i,
   output ertm_pkg::lane_type lane_o
);
   import ertm_pkg::*;

   localparam logic [32:0] RECIP_S = 33'((64'd1 << 32) / DIV_S);
   localparam logic [32:0] RECIP_C = 33'((64'd1 << 32) / DIV_C);

   lane_type    a_ff, b_ff, c_ff, c_in;
   logic [30:0] qs_in, qc_in, qs_ff, qc_ff, qsb_ff, qcb_ff;
   logic [30:0] es_in, ec_in, es_ff, ec_ff;
   logic [29:0] opnd;
   logic [31:0] rs, rc;
   logic [30:0] quo_s, quo_c;

   // horner product, scaled back to q2.30
   always_comb begin
      opnd  = SIN_LAST ? lane_i.x : lane_i.x2;
      qs_in = 31'((61'(opnd) * 61'(lane_i.ps)) >> 30);
      qc_in = 31'((61'(lane_i.x2) * 61'(lane_i.pc)) >> 30);
   end

   // quotient estimate by reciprocal, at most one low
   always_comb begin
      es_in = 31'((64'(qs_ff) * 64'(RECIP_S)) >> 32);
      ec_in = 31'((64'(qc_ff) * 64'(RECIP_C)) >> 32);
   end

   // quotient correction and next coefficient
   always_comb begin
      rs    = 32'(qsb_ff) - 32'(es_ff) * 32'(DIV_S);
      rc    = 32'(qcb_ff) - 32'(ec_ff) * 32'(DIV_C);
      quo_s = (rs >= 32'(DIV_S)) ? es_ff + 31'd1 : es_ff;
      quo_c = (rc >= 32'(DIV_C)) ? ec_ff + 31'd1 : ec_ff;
      c_in    = b_ff;
      c_in.ps = SIN_LAST ? qsb_ff : Q30_ONE - quo_s;
      c_in.pc = Q30_ONE - quo_c;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_ff   <= lane_i;
         qs_ff  <= qs_in;
         qc_ff  <= qc_in;
         b_ff   <= a_ff;
         qsb_ff <= qs_ff;
         qcb_ff <= qc_ff;
         es_ff  <= es_in;
         ec_ff  <= ec_in;
         c_ff   <= c_in;
      end
   end

   assign lane_o = c_ff;

endmodule

@@ hw/rtl/ertm_mat.sv @@
module ertm_mat (
   input  logic               clock,
   input  logic               advance,
   input  ertm_pkg::lane_type lane_h,
   input  ertm_pkg::lane_type lane_p,
   input  ertm_pkg::lane_type lane_b,
   output ertm_pkg::rsp_type  rsp
);
   import ertm_pkg::*;

   logic signed [31:0] sh, ch, sp, cp, sb, cb;

   // pair products and passed terms
   logic signed [31:0] chcb_ff, shsp_ff, sbcp_ff, shcb_ff, chsp_ff;
   logic signed [31:0] chsb_ff, cbcp_ff, sbsh_ff, shcp_ff, chcp_ff;
   logic signed [31:0] sb_ff, cb_ff, sp_ff;
   logic               mode_ff;

   // triple products and passed terms
   logic signed [31:0] t_shspsb_ff, t_chspsb_ff, t_shspcb_ff, t_chspcb_ff;
   logic signed [31:0] t_chcb_ff, t_sbcp_ff, t_shcb_ff, t_chsb_ff, t_cbcp_ff;
   logic signed [31:0] t_sbsh_ff, t_shcp_ff, t_chcp_ff, t_sp_ff;
   logic               t_mode_ff;

   logic signed [32:0] e0, e1, e2, e3, e4, e5, e6, e7, e8;
   rsp_type            rsp_in, rsp_ff;

   // undo the fold and apply quadrant signs
   function automatic void quad_sc(input lane_type l, output logic signed [31:0] s,
                                   output logic signed [31:0] c);
      logic signed [31:0] s0;
      logic signed [31:0] c0;
      s0 = l.fold ? 32'(l.pc) : 32'(l.ps);
      c0 = l.fold ? 32'(l.ps) : 32'(l.pc);
      case (l.quad)
         2'd0: begin s = s0;  c = c0;  end
         2'd1: begin s = c0;  c = -s0; end
         2'd2: begin s = -s0; c = -c0; end
         default: begin s = -c0; c = s0; end
      endcase
   endfunction

   always_comb begin
      quad_sc(lane_h, sh, ch);
      quad_sc(lane_p, sp, cp);
      quad_sc(lane_b, sb, cb);
   end

   // sums, rounding and optional transpose
   always_comb begin
      e0 = 33'(t_chcb_ff) + 33'(t_shspsb_ff);
      e1 = 33'(t_sbcp_ff);
      e2 = -33'(t_shcb_ff) + 33'(t_chspsb_ff);
      e3 = -33'(t_chsb_ff) + 33'(t_shspcb_ff);
      e4 = 33'(t_cbcp_ff);
      e5 = 33'(t_sbsh_ff) + 33'(t_chspcb_ff);
      e6 = 33'(t_shcp_ff);
      e7 = -33'(t_sp_ff);
      e8 = 33'(t_chcp_ff);
      rsp_in.m11 = to_coef(e0);
      rsp_in.m12 = to_coef(t_mode_ff ? e3 : e1);
      rsp_in.m13 = to_coef(t_mode_ff ? e6 : e2);
      rsp_in.m21 = to_coef(t_mode_ff ? e1 : e3);
      rsp_in.m22 = to_coef(e4);
      rsp_in.m23 = to_coef(t_mode_ff ? e7 : e5);
      rsp_in.m31 = to_coef(t_mode_ff ? e2 : e6);
      rsp_in.m32 = to_coef(t_mode_ff ? e5 : e7);
      rsp_in.m33 = to_coef(e8);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         chcb_ff <= mul_q30(ch, cb);
         shsp_ff <= mul_q30(sh, sp);
         sbcp_ff <= mul_q30(sb, cp);
         shcb_ff <= mul_q30(sh, cb);
         chsp_ff <= mul_q30(ch, sp);
         chsb_ff <= mul_q30(ch, sb);
         cbcp_ff <= mul_q30(cb, cp);
         sbsh_ff <= mul_q30(sb, sh);
         shcp_ff <= mul_q30(sh, cp);
         chcp_ff <= mul_q30(ch, cp);
         sb_ff   <= sb;
         cb_ff   <= cb;
         sp_ff   <= sp;
         mode_ff <= lane_h.mode;

         t_shspsb_ff <= mul_q30(shsp_ff, sb_ff);
         t_chspsb_ff <= mul_q30(chsp_ff, sb_ff);
         t_shspcb_ff <= mul_q30(shsp_ff, cb_ff);
         t_chspcb_ff <= mul_q30(chsp_ff, cb_ff);
         t_chcb_ff   <= chcb_ff;
         t_sbcp_ff   <= sbcp_ff;
         t_shcb_ff   <= shcb_ff;
         t_chsb_ff   <= chsb_ff;
         t_cbcp_ff   <= cbcp_ff;
         t_sbsh_ff   <= sbsh_ff;
         t_shcp_ff   <= shcp_ff;
         t_chcp_ff   <= chcp_ff;
         t_sp_ff     <= sp_ff;
         t_mode_ff   <= mode_ff;

         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

@@ hw/rtl/euler_to_rotation_matrix.sv @@
// Heading, pitch and bank angles (binary angles) in, 3x3 rotation matrix out.
// Request channel: req_valid / req_ready with req_data holding the three
// angles and the mode bit (0 object-to-world, 1 world-to-object transpose).
// Response channel: rsp_valid / rsp_ready with rsp_data holding the nine
// saturated Q1.15 entries, row-major.
// A request passes angle folding and squaring, then 5 series cells (one
// Horner step of sine and cosine per cell, divide by reciprocal and one
// correction), then products, sums and output rounding.
// Throughput is one request per cycle while no response is held; the three
// angles run in parallel chains of cells.
// The whole pipeline advances together. When the response register is full
// and rsp_ready is low, every stage holds and req_ready drops; a held
// response keeps its data until taken.
// Synchronous reset empties the pipeline; no response is pending after it.
module euler_to_rotation_matrix (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ertm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ertm_pkg::rsp_type rsp_data
);
   import ertm_pkg::*;

   localparam int LAT = 2 + 3 * NUM_CELLS + 3;
   localparam int DIV_S_TAB [NUM_CELLS] = '{72, 42, 20, 6, 2};
   localparam int DIV_C_TAB [NUM_CELLS] = '{90, 56, 30, 12, 2};

   logic           advance;
   logic [LAT-1:0] valid_ff, valid_in;

   logic signed [ANGLE_BITS-1:0] angles [3];
   lane_type                     chain [3][NUM_CELLS+1];

   // global stall when the response register is held
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // valid flags follow requests through the pipeline
   assign valid_in = advance ? {valid_ff[LAT-2:0], req_valid} : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff[LAT-1];

   assign angles[0] = req_data.heading;
   assign angles[1] = req_data.pitch;
   assign angles[2] = req_data.bank;

   // one chain of series cells per angle
   for (genvar a = 0; a < 3; a++) begin : g_angle
      ertm_prep u_prep (
         .clock   (clock),
         .advance (advance),
         .angle   (angles[a]),
         .mode    (req_data.mode),
         .lane    (chain[a][0])
      );
      for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
         ertm_cell #(
            .DIV_S    (DIV_S_TAB[k]),
            .DIV_C    (DIV_C_TAB[k]),
            .SIN_LAST (k == NUM_CELLS - 1)
         ) u_cell (
            .clock   (clock),
            .advance (advance),
            .lane_i  (chain[a][k]),
            .lane_o  (chain[a][k+1])
         );
      end
   end

   ertm_mat u_mat (
      .clock   (clock),
      .advance (advance),
      .lane_h  (chain[0][NUM_CELLS]),
      .lane_p  (chain[1][NUM_CELLS]),
      .lane_b  (chain[2][NUM_CELLS]),
      .rsp     (rsp_data)
   );

endmodule

@@ hw/rtl/ertm_checker.sv @@
module ertm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ertm_pkg::rsp_type rsp_data
);
   import ertm_pkg::*;

   // a held response stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a held response keeps its data
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("response data changed while stalled");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response pending after reset");

   // the block only refuses requests while a response is held
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request refused without a held response");

   // with a request held and the output free, it is taken
   a_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !rsp_valid |-> req_ready)
      else $error("request not taken with empty output");

endmodule

bind euler_to_rotation_matrix ertm_checker u_ertm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

@@ tb/tb_euler_to_rotation_matrix.sv @@
`timescale 1ns / 100ps

module tb_euler_to_rotation_matrix;
   import ertm_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // idle and stall percentages, length of the receiver hold-off
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int unsigned hold_cycles;

   rsp_type     expected_matrices[$];
   int unsigned mismatch_count;
   int unsigned orphan_count;

   euler_to_rotation_matrix DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // sine and cosine of a binary angle, both in q2.30
   function automatic void angle_sin_cos(input logic [15:0] angle, output longint s,
                                         output longint c);
      logic [31:0] turn;
      logic [1:0]  quad;
      longint unsigned r, t, x, x2, ps, pc;
      logic        fold;
      longint      s0, c0;
      turn = {angle, 16'd0};
      quad = turn[31:30];
      r    = turn[29:0];
      fold = r > 64'h2000_0000;
      t    = fold ? (64'h4000_0000 - r) : r;
      x    = (t * 64'd6746518852) >> 32;
      x2   = (x * x) >> 30;
      ps   = 64'd1 << 30;
      pc   = 64'd1 << 30;
      ps = (64'd1 << 30) - ((x2 * ps) >> 30) / 72;
      ps = (64'd1 << 30) - ((x2 * ps) >> 30) / 42;
      ps = (64'd1 << 30) - ((x2 * ps) >> 30) / 20;
      ps = (64'd1 << 30) - ((x2 * ps) >> 30) / 6;
      ps = (x * ps) >> 30;
      pc = (64'd1 << 30) - ((x2 * pc) >> 30) / 90;
      pc = (64'd1 << 30) - ((x2 * pc) >> 30) / 56;
      pc = (64'd1 << 30) - ((x2 * pc) >> 30) / 30;
      pc = (64'd1 << 30) - ((x2 * pc) >> 30) / 12;
      pc = (64'd1 << 30) - ((x2 * pc) >> 30) / 2;
      s0 = fold ? longint'(pc) : longint'(ps);
      c0 = fold ? longint'(ps) : longint'(pc);
      case (quad)
         2'd0: begin s = s0;  c = c0;  end
         2'd1: begin s = c0;  c = -s0; end
         2'd2: begin s = -s0; c = -c0; end
         default: begin s = -c0; c = s0; end
      endcase
   endfunction

   // q2.30 product, rounded half away from zero
   function automatic longint q30_product(input longint a, input longint b);
      longint unsigned ma, mb, p;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      p  = (ma * mb + (64'd1 << 29)) >> 30;
      return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
   endfunction

   // q2.30 to saturated q1.15
   function automatic logic [15:0] q30_to_q15(input longint v);
      longint unsigned m;
      longint          r;
      m = (v < 0) ? -v : v;
      m = (m + (64'd1 << 14)) >> 15;
      r = (v < 0) ? -longint'(m) : longint'(m);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   // rotation matrix of one pose
   function automatic rsp_type pose_matrix(input req_type p);
      longint     sh, ch, sp, cp, sb, cb;
      longint     e[9];
      logic [15:0] q[9];
      rsp_type    m;
      angle_sin_cos(p.heading, sh, ch);
      angle_sin_cos(p.pitch, sp, cp);
      angle_sin_cos(p.bank, sb, cb);
      e[0] = q30_product(ch, cb) + q30_product(q30_product(sh, sp), sb);
      e[1] = q30_product(sb, cp);
      e[2] = -q30_product(sh, cb) + q30_product(q30_product(ch, sp), sb);
      e[3] = -q30_product(ch, sb) + q30_product(q30_product(sh, sp), cb);
      e[4] = q30_product(cb, cp);
      e[5] = q30_product(sb, sh) + q30_product(q30_product(ch, sp), cb);
      e[6] = q30_product(sh, cp);
      e[7] = -sp;
      e[8] = q30_product(ch, cp);
      for (int k = 0; k < 9; k++) begin
         q[k] = q30_to_q15(p.mode ? e[(k % 3) * 3 + k / 3] : e[k]);
      end
      m = {q[0], q[1], q[2], q[3], q[4], q[5], q[6], q[7], q[8]};
      return m;
   endfunction

   // send one request, with random idle before it; valid stays up for the next one
   task automatic send_pose(input req_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      expected_matrices.push_back(pose_matrix(p));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [15:0] random_angle();
      case ($urandom_range(3))
         0: return 16'($urandom_range(15)) << 12;
         1: return (16'($urandom_range(15)) << 12) + 16'($urandom_range(8)) - 16'd4;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type random_pose();
      req_type p;
      p.heading = random_angle();
      p.pitch   = random_angle();
      p.bank    = random_angle();
      p.mode    = 1'($urandom_range(1));
      return p;
   endfunction

   // receiver stalls and the long hold-off
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready   <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_matrices.size() == 0) begin
            orphan_count++;
            $display("unexpected response %h", rsp_data);
         end else begin
            rsp_type want;
            want = expected_matrices.pop_front();
            if (want !== rsp_data) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %h actual %h", want, rsp_data);
            end
         end
      end
   end

   // corners: zero, quadrant edges, octant fold, extremes, both modes
   task automatic test_directed();
      logic [15:0] corners[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                  16'h2000, 16'h2001, 16'h7FFF, 16'hFFFF};
      req_type p;
      for (int k = 0; k < 8; k++) begin
         p = '{heading: corners[k], pitch: corners[(k + 3) % 8],
               bank: corners[(k + 5) % 8], mode: k[0]};
         send_pose(p);
         p.mode = ~p.mode;
         send_pose(p);
      end
      // gimbal lock, all-ones and half-turn fields
      send_pose('{heading: 16'h1234, pitch: 16'h4000, bank: 16'h0567, mode: 1'b0});
      send_pose('{heading: 16'h1234, pitch: 16'hC000, bank: 16'h0567, mode: 1'b1});
      send_pose('{heading: 16'hFFFF, pitch: 16'hFFFF, bank: 16'hFFFF, mode: 1'b1});
      send_pose('{heading: 16'h8000, pitch: 16'h8000, bank: 16'h8000, mode: 1'b0});
   endtask

   task automatic test_random(input int unsigned n, input int unsigned idle_pct,
                              input int unsigned stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < n; i++) send_pose(random_pose());
   endtask

   // receiver holds off while requests keep coming
   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_cycles    = 80;
      for (int i = 0; i < 60; i++) send_pose(random_pose());
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_ready      = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_cycles    = 0;
      mismatch_count = 0;
      orphan_count   = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random(300, 0, 0);
      test_random(300, 53, 0);
      test_random(300, 0, 53);
      test_random(300, 16, 16);
      test_backpressure();
      req_valid      <= 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;

      while (expected_matrices.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (mismatch_count == 0 && orphan_count == 0 && expected_matrices.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // timeout
   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
